/* hdl/sset_pkg.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// sset_pkg
// Types, codes and sizes shared by the sparse-set handle table.
// -----------------------------------------------------------------------------
package sset_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int HW          = 6;   // handle / slot field width
	localparam int CW          = 7;   // live count width
	localparam int GRP_W       = 8;   // bitmap bits per free-search group
	localparam int NGRP        = MAX_ENTRIES / GRP_W;
	localparam int GRP_IW      = $clog2(GRP_W);
	localparam int NG_IW       = $clog2(NGRP);

	localparam logic [1:0] CMD_CREATE  = 2'd0;
	localparam logic [1:0] CMD_DESTROY = 2'd1;
	localparam logic [1:0] CMD_LOOKUP  = 2'd2;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_FULL = 2'd1;
	localparam logic [1:0] STAT_BAD  = 2'd2;

	typedef struct packed {
		logic [1:0]    command;
		logic [HW-1:0] handle;
	} req_t;

	typedef struct packed {
		logic [1:0]    status;
		logic [HW-1:0] result_handle;
		logic [HW-1:0] dense_slot;
		logic [HW-1:0] moved_from_slot;
		logic          moved;
		logic [CW-1:0] live_count;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_FIN
	} state_t;

endpackage
`default_nettype wire

/* hdl/sset_free_find.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// sset_free_find
// Lowest free handle: registered per-group search, then group select.
// -----------------------------------------------------------------------------
module sset_free_find (
	input  wire logic                       clk,
	input  wire logic [sset_pkg::MAX_ENTRIES-1:0] live,
	output logic [sset_pkg::HW-1:0]         free_handle
);
	import sset_pkg::*;

	logic [NGRP-1:0]   grp_free_s1;
	logic [GRP_IW-1:0] grp_idx_s1 [NGRP];
	logic [NGRP-1:0]   grp_free_d;
	logic [GRP_IW-1:0] grp_idx_d [NGRP];
	logic [NG_IW-1:0]  gsel;

	// per group: any zero bit, and the lowest zero bit
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_free_d[g] = ~&live[g*GRP_W +: GRP_W];
			grp_idx_d[g]  = '0;
			for (int b = GRP_W-1; b >= 0; b--) begin
				if (!live[g*GRP_W + b]) begin
					grp_idx_d[g] = GRP_IW'(b);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		grp_free_s1 <= grp_free_d;
		for (int g = 0; g < NGRP; g++) begin
			grp_idx_s1[g] <= grp_idx_d[g];
		end
	end

	always_comb begin
		gsel = '0;
		for (int g = NGRP-1; g >= 0; g--) begin
			if (grp_free_s1[g]) begin
				gsel = NG_IW'(g);
			end
		end
	end

	assign free_handle = {gsel, grp_idx_s1[gsel]};

endmodule
`default_nettype wire

/* hdl/sparse_set_handle_table.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// sparse_set_handle_table
// Handle table over a packed dense array: create, destroy (swap-remove), lookup.
// -----------------------------------------------------------------------------
//  channel   ports                 handshake
//  command   req (req_t)           taken at clk edge with start && !busy
//  result    rsp (rsp_t)           held until the next result, marked by done
//
//  A live destroy/lookup or a create that succeeds passes through EXEC and FIN
//  to the done cycle; rejected items give done straight from EXEC. The next
//  start is taken in the done cycle, so no new item is taken before the last
//  is done. FIN waits on the registered reads of the two table memories and the registered free search.
//  Reset clears the live bitmap and count at once; no clearing pass.
//  The receiver cannot stall: each result's done strobe shows for exactly one cycle.
// -----------------------------------------------------------------------------
module sparse_set_handle_table (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire sset_pkg::req_t  req,
	output logic                 busy,
	output logic                 done,
	output sset_pkg::rsp_t       rsp
);
	import sset_pkg::*;

	state_t state_q, state_d;
	req_t   req_q;
	rsp_t   rsp_q, rsp_d;
	logic   done_q, done_d;

	logic [CW-1:0]          count_q, count_d;
	logic [MAX_ENTRIES-1:0] live_q;
	logic                   live_we, live_val;
	logic [HW-1:0]          live_idx;

	// handle -> slot and slot -> handle tables
	logic [HW-1:0] h2s_mem [MAX_ENTRIES];
	logic [HW-1:0] s2h_mem [MAX_ENTRIES];
	logic [HW-1:0] h2s_rd_q, s2h_rd_q;
	logic          h2s_we, s2h_we;
	logic [HW-1:0] h2s_waddr, h2s_wdata, s2h_waddr, s2h_wdata;

	logic [HW-1:0] free_handle;
	logic [CW-1:0] last;
	logic [HW-1:0] slot;

	sset_free_find u_find (
		.clk         (clk),
		.live        (live_q),
		.free_handle (free_handle)
	);

	assign last = count_q - CW'(1);
	assign slot = h2s_rd_q;

	always_ff @(posedge clk) begin
		if (h2s_we) begin
			h2s_mem[h2s_waddr] <= h2s_wdata;
		end
		if (s2h_we) begin
			s2h_mem[s2h_waddr] <= s2h_wdata;
		end
		h2s_rd_q <= h2s_mem[req_q.handle];
		s2h_rd_q <= s2h_mem[last[HW-1:0]];
	end

	always_comb begin
		state_d   = state_q;
		done_d    = 1'b0;
		rsp_d     = '0;
		count_d   = count_q;
		live_we   = 1'b0;
		live_val  = 1'b0;
		live_idx  = req_q.handle;
		h2s_we    = 1'b0;
		h2s_waddr = free_handle;
		h2s_wdata = count_q[HW-1:0];
		s2h_we    = 1'b0;
		s2h_waddr = count_q[HW-1:0];
		s2h_wdata = free_handle;

		rsp_d.result_handle = req_q.handle;
		rsp_d.live_count    = count_q;

		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				// reject here; otherwise table reads are in flight
				priority if (req_q.command == CMD_CREATE) begin
					if (count_q == CW'(MAX_ENTRIES)) begin
						rsp_d.status        = STAT_FULL;
						rsp_d.result_handle = '0;
						done_d  = 1'b1;
						state_d = ST_IDLE;
					end else begin
						state_d = ST_FIN;
					end
				end else if ((req_q.command == CMD_DESTROY || req_q.command == CMD_LOOKUP)
						&& live_q[req_q.handle]) begin
					state_d = ST_FIN;
				end else begin
					rsp_d.status = STAT_BAD;
					done_d  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_FIN: begin
				done_d  = 1'b1;
				state_d = ST_IDLE;
				rsp_d.status = STAT_OK;
				priority if (req_q.command == CMD_CREATE) begin
					h2s_we   = 1'b1;
					s2h_we   = 1'b1;
					live_we  = 1'b1;
					live_val = 1'b1;
					live_idx = free_handle;
					count_d  = count_q + CW'(1);
					rsp_d.result_handle = free_handle;
					rsp_d.dense_slot    = count_q[HW-1:0];
					rsp_d.live_count    = count_q + CW'(1);
				end else if (req_q.command == CMD_DESTROY) begin
					// swap-remove: last entry moves into the freed slot
					if (slot != last[HW-1:0]) begin
						s2h_we    = 1'b1;
						s2h_waddr = slot;
						s2h_wdata = s2h_rd_q;
						h2s_we    = 1'b1;
						h2s_waddr = s2h_rd_q;
						h2s_wdata = slot;
						rsp_d.moved = 1'b1;
					end
					live_we  = 1'b1;
					live_val = 1'b0;
					count_d  = last;
					rsp_d.dense_slot      = slot;
					rsp_d.moved_from_slot = last[HW-1:0];
					rsp_d.live_count      = last;
				end else begin
					rsp_d.dense_slot = slot;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			count_q <= '0;
			live_q  <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			count_q <= count_d;
			if (live_we) begin
				live_q[live_idx] <= live_val;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			req_q <= req;
		end
		if (done_d) begin
			rsp_q <= rsp_d;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

`ifndef ASSERT_OFF
	a_count_matches_bitmap: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(live_q) == int'(count_q))
		else $error("live count disagrees with bitmap");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ENTRIES))
		else $error("live count above table size");

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without work");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held two cycles");

	a_create_binds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && req_q.command == CMD_CREATE) |=> live_q[$past(free_handle)])
		else $error("created handle not live");
`endif

endmodule
`default_nettype wire
